[design/ted_pkg.sv]
// Shared types and constants for the text encoding detector.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ted_pkg;

  // Encoding result codes.
  localparam int unsigned CODE_W = 3;
  localparam logic [CODE_W-1:0] CODE_ANSI       = 3'd0;
  localparam logic [CODE_W-1:0] CODE_UTF16LE    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_UTF16BE    = 3'd2;
  localparam logic [CODE_W-1:0] CODE_UTF8_BOM   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_UTF8_PLAIN = 3'd4;

  // Byte order mark values.
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;

  // UTF-8 lead and continuation patterns.
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;

  // Byte held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

`default_nettype wire

[design/ted_in_stage.sv]
// Input register of the text encoding detector.
// Depends on ted_pkg for the byte item type.
`default_nettype none

module ted_in_stage
  import ted_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       advance,
  output logic            item_vld,
  output byte_item_t      item
);

  logic       vld_r;
  logic       vld_nxt;
  byte_item_t item_r;
  logic       load;

  // The register frees up when the core consumes its byte.
  assign in_stall = vld_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

[design/ted_core.sv]
// Per-byte state update and encoding decision of the text encoding detector.
// Depends on ted_pkg for codes, patterns and the item and result types.
`default_nettype none

module ted_core
  import ted_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire byte_item_t item,
  output result_t         result
);

  logic [1:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [1:0] pending_r, pending_nxt;
  logic       invalid_r, invalid_nxt;
  logic       third_r, third_nxt;
  logic [7:0] b;
  logic [CODE_W-1:0] code;

  assign b = item.data_byte;

  // Capture the leading bytes and the third byte of a UTF-8 BOM.
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    case (bytes_seen_r)
      2'd0: first_nxt = b;
      2'd1: second_nxt = b;
      2'd2: third_nxt = (first_r == BOM_EF) && (second_r == BOM_BB) && (b == BOM_BF);
      default: ;
    endcase
    bytes_seen_nxt = (bytes_seen_r == 2'd3) ? 2'd3 : bytes_seen_r + 2'd1;
  end

  // Simplified UTF-8 check: one-, two- and three-byte sequences only.
  always_comb begin
    pending_nxt = pending_r;
    invalid_nxt = invalid_r;
    if (pending_r != 2'd0) begin
      if ((b & MASK_CONT) != PAT_CONT) begin
        invalid_nxt = 1'b1;
      end
      pending_nxt = pending_r - 2'd1;
    end else if ((b & MASK_ASCII) == 8'h00) begin
      pending_nxt = 2'd0;
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      pending_nxt = 2'd1;
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      pending_nxt = 2'd2;
    end else begin
      invalid_nxt = 1'b1;
    end
  end

  // Decision on the final byte, from the updated state.
  always_comb begin
    if (bytes_seen_nxt < 2'd2) begin
      code = CODE_ANSI;
    end else if (first_nxt == BOM_FF && second_nxt == BOM_FE) begin
      code = CODE_UTF16LE;
    end else if (first_nxt == BOM_FE && second_nxt == BOM_FF) begin
      code = CODE_UTF16BE;
    end else if (third_nxt) begin
      code = CODE_UTF8_BOM;
    end else if (!invalid_nxt && pending_nxt == 2'd0) begin
      code = CODE_UTF8_PLAIN;
    end else begin
      code = CODE_ANSI;
    end
  end

  assign result.vld  = advance && item.last_byte;
  assign result.code = code;

  // State registers; everything clears after the final byte of a buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= 2'd0;
      first_r      <= 8'h00;
      second_r     <= 8'h00;
      pending_r    <= 2'd0;
      invalid_r    <= 1'b0;
      third_r      <= 1'b0;
    end else if (advance) begin
      if (item.last_byte) begin
        bytes_seen_r <= 2'd0;
        first_r      <= 8'h00;
        second_r     <= 8'h00;
        pending_r    <= 2'd0;
        invalid_r    <= 1'b0;
        third_r      <= 1'b0;
      end else begin
        bytes_seen_r <= bytes_seen_nxt;
        first_r      <= first_nxt;
        second_r     <= second_nxt;
        pending_r    <= pending_nxt;
        invalid_r    <= invalid_nxt;
        third_r      <= third_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[design/ted_out_stage.sv]
// Output register of the text encoding detector.
// Depends on ted_pkg for the result type and code width.
`default_nettype none

module ted_out_stage
  import ted_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire result_t            result,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CODE_W-1:0]       out_encoding_code
);

  logic              vld_r, vld_nxt;
  logic [CODE_W-1:0] code_r;

  // A new result only arrives when the register is empty or being taken.
  always_comb begin
    vld_nxt = vld_r;
    if (result.vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.vld) begin
      code_r <= result.code;
    end
  end

  assign out_valid         = vld_r;
  assign out_encoding_code = code_r;

endmodule

`default_nettype wire

[design/text_encoding_detector_unit.sv]
// Top level of the text encoding detector.
// Depends on ted_pkg, ted_in_stage, ted_core and ted_out_stage.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data_byte, in_last_byte) takes
//   one byte of a text buffer per transaction; in_last_byte marks the final
//   byte. The result channel (out_valid, out_stall, out_encoding_code) gives
//   one encoding code per buffer, after its final byte, and nothing for the
//   other bytes.
//   Throughput is one byte per cycle unless a stalled result holds the
//   output register; the state update in the core is combinational logic
//   between the input register and the output register.
//   The code for the final byte passes from the input register through the
//   core into the output register, which drives out_valid.
//   The block takes the next byte while a result waits in the output
//   register; when the receiver stalls with a result held and the input
//   register is full, in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   buffer state, so the first byte after reset starts a new buffer.
`default_nettype none

module text_encoding_detector_unit
  import ted_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CODE_W-1:0]      out_encoding_code
);

  logic       item_vld;
  byte_item_t item;
  logic       advance;
  result_t    result;

  // The core consumes a byte whenever the output register can take a result.
  assign advance = item_vld && (!out_valid || !out_stall);

  ted_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_vld     (item_vld),
    .item         (item)
  );

  ted_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  ted_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .result            (result),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_encoding_code (out_encoding_code)
  );

endmodule

`default_nettype wire

[design/ted_checker.sv]
// Port-level checker for the text encoding detector, bound to the top level.
// Depends on ted_pkg for the result codes.
`default_nettype none

module ted_checker
  import ted_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [7:0]        in_data_byte,
  input wire logic              in_last_byte,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CODE_W-1:0] out_encoding_code
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its code.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_encoding_code))
    else $error("result changed while stalled");

  // Only the five defined codes are ever shown.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_encoding_code <= CODE_UTF8_PLAIN))
    else $error("undefined encoding code");

  // The input only backs up behind a held, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A stalled byte stays offered with the same payload.
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("input transaction changed while stalled");

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_data_byte      (in_data_byte),
  .in_last_byte      (in_last_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_encoding_code (out_encoding_code)
);

`default_nettype wire

[test/tb_text_encoding_detector_unit.sv]
// Testbench for text_encoding_detector_unit: streams byte buffers and checks
// one encoding code per buffer against a scoreboard that predicts it.
// Depends on ted_pkg and the text_encoding_detector_unit RTL.
`timescale 1ns / 100ps

module tb_text_encoding_detector_unit;
  import ted_pkg::*;

  localparam int unsigned RANDOM_BYTES   = 1800;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  // Predicts the encoding code of each buffer and holds the codes in flight.
  class encoding_scoreboard;
    logic [1:0]        byte_count;
    logic [7:0]        lead_byte;
    logic [7:0]        next_byte;
    logic [1:0]        conts_owed;
    bit                utf8_broken;
    bit                bom8_seen;
    logic [CODE_W-1:0] expected_codes[$];
    int unsigned       failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      byte_count  = 2'd0;
      lead_byte   = 8'h00;
      next_byte   = 8'h00;
      conts_owed  = 2'd0;
      utf8_broken = 1'b0;
      bom8_seen   = 1'b0;
    endfunction

    // Updates the buffer state for one accepted byte; queues a code on the last one.
    function void record_byte(logic [7:0] b, logic last);
      logic [CODE_W-1:0] code;
      if (byte_count == 2'd0) begin
        lead_byte = b;
      end else if (byte_count == 2'd1) begin
        next_byte = b;
      end else if (byte_count == 2'd2) begin
        bom8_seen = (lead_byte == BOM_EF) && (next_byte == BOM_BB) && (b == BOM_BF);
      end

      // Simplified UTF-8 check: one-, two- and three-byte sequences only.
      if (conts_owed != 2'd0) begin
        if ((b & MASK_CONT) != PAT_CONT) utf8_broken = 1'b1;
        conts_owed = conts_owed - 2'd1;
      end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        conts_owed = 2'd1;
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        conts_owed = 2'd2;
      end else if ((b & MASK_ASCII) != 8'h00) begin
        utf8_broken = 1'b1;
      end

      if (byte_count != 2'd3) byte_count = byte_count + 2'd1;

      if (last) begin
        if (byte_count < 2'd2) begin
          code = CODE_ANSI;
        end else if (lead_byte == BOM_FF && next_byte == BOM_FE) begin
          code = CODE_UTF16LE;
        end else if (lead_byte == BOM_FE && next_byte == BOM_FF) begin
          code = CODE_UTF16BE;
        end else if (bom8_seen) begin
          code = CODE_UTF8_BOM;
        end else if (!utf8_broken && conts_owed == 2'd0) begin
          code = CODE_UTF8_PLAIN;
        end else begin
          code = CODE_ANSI;
        end
        expected_codes.push_back(code);
        clear();
      end
    endfunction

    // Compares one accepted result with the oldest predicted code.
    function void check_code(logic [CODE_W-1:0] actual);
      logic [CODE_W-1:0] wanted;
      if (expected_codes.size() == 0) begin
        $error("unexpected result: encoding_code actual %0d", actual);
        failures++;
      end else begin
        wanted = expected_codes.pop_front();
        if (actual !== wanted) begin
          $error("encoding_code mismatch: expected %0d, actual %0d", wanted, actual);
          failures++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [CODE_W-1:0] out_encoding_code;

  encoding_scoreboard encodings;
  bit                 gaps_on = 1'b1;
  int unsigned        quiet_cycles = 0;
  logic [7:0]         text_bytes[$];

  text_encoding_detector_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_encoding_code(out_encoding_code)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // The receiver stalls at random while gaps are enabled.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 13);
  end

  // Both channels are sampled mid-cycle, where every signal has settled for the next edge.
  always @(negedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        encodings.record_byte(in_data_byte, in_last_byte);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        encodings.check_code(out_encoding_code);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Ends the run when no transaction has happened for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_text_encoding_detector_unit NOT OK");
    $finish;
  end

  // Offers one byte, with random idle cycles ahead of it, and holds it until taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // Holds the sender off until every predicted code has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (encodings.expected_codes.size() != 0) @(posedge clk);
  endtask

  // Builds a random buffer: mostly well-formed UTF-8, some broken, some pure noise.
  task automatic build_text();
    int unsigned pick;
    int unsigned mode;
    int unsigned n_chars;
    text_bytes.delete();

    // Optional byte order mark, sometimes cut to its first two bytes.
    pick = $urandom_range(99);
    if (pick < 8) begin
      text_bytes.push_back(BOM_FF);
      text_bytes.push_back(BOM_FE);
    end else if (pick < 16) begin
      text_bytes.push_back(BOM_FE);
      text_bytes.push_back(BOM_FF);
    end else if (pick < 26) begin
      text_bytes.push_back(BOM_EF);
      text_bytes.push_back(BOM_BB);
      text_bytes.push_back(BOM_BF);
    end else if (pick < 30) begin
      text_bytes.push_back(BOM_EF);
      text_bytes.push_back(BOM_BB);
    end

    n_chars = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 0);
    mode    = $urandom_range(99);
    if (mode >= 85) begin
      text_bytes.delete();
      repeat ($urandom_range(8, 1)) text_bytes.push_back(8'($urandom));
    end else begin
      repeat (n_chars) begin
        case ($urandom_range(2))
          0: begin
            text_bytes.push_back({1'b0, 7'($urandom)});
          end
          1: begin
            text_bytes.push_back({3'b110, 5'($urandom)});
            text_bytes.push_back({2'b10, 6'($urandom)});
          end
          default: begin
            text_bytes.push_back({4'b1110, 4'($urandom)});
            text_bytes.push_back({2'b10, 6'($urandom)});
            text_bytes.push_back({2'b10, 6'($urandom)});
          end
        endcase
      end
      // Corrupt one byte, or cut the buffer short.
      if (mode >= 75 && text_bytes.size() != 0) begin
        text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom);
      end else if (mode >= 65 && text_bytes.size() > 1) begin
        void'(text_bytes.pop_back());
      end
    end
    if (text_bytes.size() == 0) text_bytes.push_back({1'b0, 7'($urandom)});
  endtask

  initial begin
    int unsigned sent;
    int unsigned rounds;
    encodings = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // One-byte buffers are ANSI whatever they hold.
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b1);
    // UTF-16 byte order marks, little and big endian.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // UTF-8 mark, then only its first two bytes.
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBB, 1'b1);
    // Pure ASCII at the field extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // Valid two- and three-byte sequences.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    // A stray continuation byte fails the check for good.
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // A sequence truncated by the end of the buffer.
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b1);
    // A lead byte outside the accepted forms.
    send_byte(8'hF8, 1'b0);
    send_byte(8'h41, 1'b1);

    wait_drained();

    // Random buffers, with a stretch free of gaps and one more full drain.
    sent   = 0;
    rounds = 0;
    while (sent < RANDOM_BYTES) begin
      gaps_on = !(sent >= 400 && sent < 800);
      if (rounds == 120) wait_drained();
      build_text();
      send_text();
      sent += text_bytes.size();
      rounds++;
    end

    gaps_on = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (encodings.failures == 0) begin
      $display("tb_text_encoding_detector_unit OK");
    end else begin
      $display("tb_text_encoding_detector_unit NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ted_pkg.sv
design/ted_in_stage.sv
design/ted_core.sv
design/ted_out_stage.sv
design/text_encoding_detector_unit.sv
design/ted_checker.sv
test/tb_text_encoding_detector_unit.sv
